/* rtl/flfa_pkg.sv */
// ============================================================================
// flfa_pkg: shared types and constants of the free list fit allocator
// Holds the request and response item types, register indexes, fit policy
// codes, status codes and the fixed field widths.
// ============================================================================
package flfa_pkg;

   // Fixed field widths.
   localparam int unsigned SIZE_BITS  = 16;
   localparam int unsigned LEN_BITS   = 17;
   localparam int unsigned HDR_BITS   = 8;
   localparam int unsigned ALIGN_BITS = 13;
   localparam int unsigned POL_BITS   = 2;
   localparam int unsigned CSR_IDX_BITS  = 3;
   localparam int unsigned CSR_DATA_BITS = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOTAL_SIZE   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BASE_ADDRESS = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEADER_SIZE  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIT_POLICY   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ALIGNMENT    = 3'd4;

   // Register reset values.
   localparam logic [SIZE_BITS-1:0]  TOTAL_SIZE_RST   = 16'd1000;
   localparam logic [SIZE_BITS-1:0]  BASE_ADDRESS_RST = 16'd0;
   localparam logic [HDR_BITS-1:0]   HEADER_SIZE_RST  = 8'd0;
   localparam logic [POL_BITS-1:0]   FIT_POLICY_RST   = 2'd0;
   localparam logic [ALIGN_BITS-1:0] ALIGNMENT_RST    = 13'd0;

   // Fit policy codes; the unused code behaves as first fit.
   localparam logic [POL_BITS-1:0] POL_FIRST = 2'd0;
   localparam logic [POL_BITS-1:0] POL_BEST  = 2'd1;
   localparam logic [POL_BITS-1:0] POL_WORST = 2'd2;

   // Command codes.
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Status codes.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_NOFIT = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // Request item.
   typedef struct packed {
      logic                 command;
      logic [SIZE_BITS-1:0] request_size;
      logic [SIZE_BITS-1:0] free_address;
   } req_type;

   // Response item.
   typedef struct packed {
      logic [SIZE_BITS-1:0] granted_address;
      logic [1:0]           status;
   } rsp_type;

endpackage

/* rtl/flfa_rem.sv */
// ============================================================================
// flfa_rem: serial remainder unit
// Restoring division of a 16-bit request by the 13-bit alignment, one
// quotient bit per cycle, keeping only the remainder.
// ============================================================================
module flfa_rem (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [flfa_pkg::SIZE_BITS-1:0]      dividend,
   input  logic [flfa_pkg::ALIGN_BITS-1:0]     divisor,
   output logic                                done,
   output logic [flfa_pkg::ALIGN_BITS-1:0]     remainder
);

   localparam int unsigned AB = flfa_pkg::ALIGN_BITS;
   localparam int unsigned SB = flfa_pkg::SIZE_BITS;
   localparam int unsigned CB = $clog2(SB + 1);

   logic [SB-1:0] dvd_ff, dvd_in;
   logic [AB-1:0] dvs_ff, dvs_in;
   logic [AB-1:0] rem_ff, rem_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [AB:0]   trial;

   // One restoring step: shift the next dividend bit in, subtract if it fits.
   always_comb begin
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[SB-1]};
      if (start) begin
         dvd_in = dividend;
         dvs_in = divisor;
         rem_in = '0;
         cnt_in = CB'(SB);
         run_in = 1'b1;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[SB-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = AB'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[AB-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CB'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/free_list_fit_allocator.sv */
// ============================================================================
// free_list_fit_allocator: free list allocator with first, best or worst fit
// Top level: configuration registers, free list memory and the sequencer.
// ============================================================================
// The free list sits in a single-port-write, registered-read memory and is
// walked one entry per cycle. An allocate item first passes through the
// serial remainder unit when alignment is nonzero, then scans the list;
// first fit stops at the first hit. When a granted entry empties, the
// entries behind it are moved down one place, one per cycle. A free item
// moves every entry up one place before the new one goes to the head; a
// free on a full list is dropped. After reset and after each configuration
// write the list is rebuilt as a single region, and while that is pending no
// item is accepted. Only one item is in work at a time; its result is held
// until taken.
module free_list_fit_allocator #(
   parameter int unsigned MAX_BLOCKS = 16,
   parameter int unsigned ADDR_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  flfa_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output flfa_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [flfa_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [flfa_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int unsigned IDX_BITS  = $clog2(MAX_BLOCKS);
   localparam int unsigned CNT_BITS  = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned LB        = flfa_pkg::LEN_BITS;
   localparam int unsigned SB        = flfa_pkg::SIZE_BITS;
   localparam int unsigned AB        = flfa_pkg::ALIGN_BITS;
   localparam int unsigned SUM_BITS  = (ADDR_BITS > LB) ? ADDR_BITS : LB;
   localparam int unsigned WIDE_BITS = (ADDR_BITS > SB) ? ADDR_BITS : SB;

   typedef struct packed {
      logic [ADDR_BITS-1:0] start;
      logic [LB-1:0]        length;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_NEED, ST_SCAN, ST_UPDATE, ST_REMOVE, ST_PUSH, ST_DONE
   } state_type;

   // Configuration registers.
   logic [SB-1:0]                     total_size_ff;
   logic [SB-1:0]                     base_address_ff;
   logic [flfa_pkg::HDR_BITS-1:0]     header_size_ff;
   logic [flfa_pkg::POL_BITS-1:0]     fit_policy_ff;
   logic [AB-1:0]                     alignment_ff;
   logic                              csr_hit;

   // Sequencer state.
   state_type            state_ff, state_in;
   logic                 restart_ff, restart_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [CNT_BITS-1:0]  rd_idx_ff, rd_idx_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [IDX_BITS-1:0]  chk_idx_ff, chk_idx_in;
   logic                 mv_vld_ff, mv_vld_in;
   logic [IDX_BITS-1:0]  mv_dst_ff, mv_dst_in;
   logic                 found_ff, found_in;
   logic [IDX_BITS-1:0]  pick_idx_ff, pick_idx_in;
   entry_type            pick_ff, pick_in;
   flfa_pkg::req_type    req_ff, req_in;
   logic [LB-1:0]        need_ff, need_in;
   flfa_pkg::rsp_type    res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   flfa_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   // Memory ports.
   entry_type            mem [MAX_BLOCKS];
   entry_type            rd_data_ff;
   logic                 mem_we;
   logic [IDX_BITS-1:0]  mem_waddr;
   entry_type            mem_wdata;
   logic [IDX_BITS-1:0]  mem_raddr;

   // Remainder unit.
   logic                 div_start;
   logic                 div_done;
   logic [AB-1:0]        div_rem;

   // Datapath helpers.
   logic                 fits;
   logic                 take;
   logic                 first_only;
   logic [AB-1:0]        pad;
   logic [SUM_BITS-1:0]  sum_start;
   logic [LB-1:0]        new_len;
   logic [WIDE_BITS-1:0] pick_wide;
   logic [WIDE_BITS-1:0] fa_wide;
   logic [WIDE_BITS-1:0] base_wide;

   flfa_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_data.request_size),
      .divisor   (alignment_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // Configuration writes; any valid index restarts the list.
   always_comb begin
      case (csr_index)
         flfa_pkg::CSR_TOTAL_SIZE:   csr_hit = 1'b1;
         flfa_pkg::CSR_BASE_ADDRESS: csr_hit = 1'b1;
         flfa_pkg::CSR_HEADER_SIZE:  csr_hit = 1'b1;
         flfa_pkg::CSR_FIT_POLICY:   csr_hit = 1'b1;
         flfa_pkg::CSR_ALIGNMENT:    csr_hit = 1'b1;
         default:                    csr_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_size_ff   <= flfa_pkg::TOTAL_SIZE_RST;
         base_address_ff <= flfa_pkg::BASE_ADDRESS_RST;
         header_size_ff  <= flfa_pkg::HEADER_SIZE_RST;
         fit_policy_ff   <= flfa_pkg::FIT_POLICY_RST;
         alignment_ff    <= flfa_pkg::ALIGNMENT_RST;
      end else if (csr_we) begin
         case (csr_index)
            flfa_pkg::CSR_TOTAL_SIZE:   total_size_ff   <= csr_wdata;
            flfa_pkg::CSR_BASE_ADDRESS: base_address_ff <= csr_wdata;
            flfa_pkg::CSR_HEADER_SIZE:  header_size_ff  <= csr_wdata[flfa_pkg::HDR_BITS-1:0];
            flfa_pkg::CSR_FIT_POLICY:   fit_policy_ff   <= csr_wdata[flfa_pkg::POL_BITS-1:0];
            flfa_pkg::CSR_ALIGNMENT:    alignment_ff    <= csr_wdata[AB-1:0];
            default: ;
         endcase
      end
   end

   // Fit test on the entry just read and the policy's choice among hits.
   always_comb begin
      fits       = rd_data_ff.length >= need_ff;
      first_only = (fit_policy_ff != flfa_pkg::POL_BEST) &&
                   (fit_policy_ff != flfa_pkg::POL_WORST);
      take       = fits && (!found_ff ||
                   ((fit_policy_ff == flfa_pkg::POL_BEST) &&
                    (rd_data_ff.length < pick_ff.length)) ||
                   ((fit_policy_ff == flfa_pkg::POL_WORST) &&
                    (rd_data_ff.length > pick_ff.length)));
      pad        = ((alignment_ff != '0) && (div_rem != '0)) ?
                   AB'(alignment_ff - div_rem) : '0;
      sum_start  = SUM_BITS'(pick_ff.start) + SUM_BITS'(need_ff);
      new_len    = pick_ff.length - need_ff;
      pick_wide  = WIDE_BITS'(pick_ff.start);
      fa_wide    = WIDE_BITS'(req_ff.free_address);
      base_wide  = WIDE_BITS'(base_address_ff);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      restart_in   = restart_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      mv_vld_in    = 1'b0;
      mv_dst_in    = mv_dst_ff;
      found_in     = found_ff;
      pick_idx_in  = pick_idx_ff;
      pick_in      = pick_ff;
      req_in       = req_ff;
      need_in      = need_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_raddr    = '0;
      req_ready    = (state_ff == ST_IDLE) && !restart_ff;

      case (state_ff)
         ST_IDLE: begin
            if (restart_ff) begin
               // Rebuild the list as the single initial region.
               mem_we           = 1'b1;
               mem_wdata.start  = base_wide[ADDR_BITS-1:0];
               mem_wdata.length = LB'(total_size_ff);
               count_in         = CNT_BITS'(1);
               restart_in       = 1'b0;
            end else if (req_valid) begin
               req_in   = req_data;
               found_in = 1'b0;
               if (req_data.command == flfa_pkg::CMD_FREE) begin
                  if (count_ff >= CNT_BITS'(MAX_BLOCKS)) begin
                     res_in   = '{granted_address: '0, status: flfa_pkg::STAT_FULL};
                     state_in = ST_DONE;
                  end else begin
                     rd_idx_in = count_ff;
                     state_in  = ST_PUSH;
                  end
               end else if (alignment_ff != '0) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in = ST_NEED;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_NEED;
            end
         end
         ST_NEED: begin
            need_in   = LB'(req_ff.request_size) + LB'(pad) + LB'(header_size_ff);
            rd_idx_in = '0;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            // Issue one read a cycle; judge the entry read the cycle before.
            if (rd_idx_ff < count_ff) begin
               mem_raddr  = rd_idx_ff[IDX_BITS-1:0];
               chk_vld_in = 1'b1;
               chk_idx_in = rd_idx_ff[IDX_BITS-1:0];
               rd_idx_in  = rd_idx_ff + 1'b1;
            end
            if (chk_vld_ff && take) begin
               found_in    = 1'b1;
               pick_idx_in = chk_idx_ff;
               pick_in     = rd_data_ff;
            end
            if (chk_vld_ff && fits && !found_ff && first_only) begin
               state_in = ST_UPDATE;
            end else if ((rd_idx_ff >= count_ff) && !chk_vld_ff) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!found_ff) begin
               res_in   = '{granted_address: '0, status: flfa_pkg::STAT_NOFIT};
               state_in = ST_DONE;
            end else begin
               res_in = '{granted_address: pick_wide[SB-1:0], status: flfa_pkg::STAT_OK};
               if (new_len != '0) begin
                  mem_we           = 1'b1;
                  mem_waddr        = pick_idx_ff;
                  mem_wdata.start  = sum_start[ADDR_BITS-1:0];
                  mem_wdata.length = new_len;
                  state_in         = ST_DONE;
               end else begin
                  rd_idx_in = CNT_BITS'(pick_idx_ff) + 1'b1;
                  state_in  = ST_REMOVE;
               end
            end
         end
         ST_REMOVE: begin
            // Close the gap: each later entry moves down one place.
            if (rd_idx_ff < count_ff) begin
               mem_raddr = rd_idx_ff[IDX_BITS-1:0];
               mv_vld_in = 1'b1;
               mv_dst_in = IDX_BITS'(rd_idx_ff - 1'b1);
               rd_idx_in = rd_idx_ff + 1'b1;
            end else if (!mv_vld_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_PUSH: begin
            // Move every entry up one place, last first, then fill the head.
            if (rd_idx_ff != '0) begin
               mem_raddr = IDX_BITS'(rd_idx_ff - 1'b1);
               mv_vld_in = 1'b1;
               mv_dst_in = rd_idx_ff[IDX_BITS-1:0];
               rd_idx_in = rd_idx_ff - 1'b1;
            end else if (!mv_vld_ff) begin
               mem_we           = 1'b1;
               mem_waddr        = '0;
               mem_wdata.start  = fa_wide[ADDR_BITS-1:0];
               mem_wdata.length = LB'(req_ff.request_size);
               count_in         = count_ff + 1'b1;
               res_in           = '{granted_address: '0, status: flfa_pkg::STAT_OK};
               state_in         = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A moved entry is written in the cycle after its read.
      if (mv_vld_ff) begin
         mem_we    = 1'b1;
         mem_waddr = mv_dst_ff;
         mem_wdata = rd_data_ff;
      end

      if (csr_we && csr_hit) begin
         restart_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         restart_ff   <= 1'b1;
         count_ff     <= CNT_BITS'(1);
         chk_vld_ff   <= 1'b0;
         mv_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         restart_ff   <= restart_in;
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         mv_vld_ff    <= mv_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff   <= rd_idx_in;
      chk_idx_ff  <= chk_idx_in;
      mv_dst_ff   <= mv_dst_in;
      pick_idx_ff <= pick_idx_in;
      pick_ff     <= pick_in;
      req_ff      <= req_in;
      need_ff     <= need_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Free list memory: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/sv/flfa_allocation_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flfa_allocation_checker: grant predictor and response scoreboard
// Watches the request, response and register ports of the free list
// allocator. It keeps its own copy of the settings and of the free list,
// works out the response for every accepted item, and compares each taken
// response field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module flfa_allocation_checker #(
   parameter int unsigned MAX_BLOCKS = 16,
   parameter int unsigned ADDR_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  flfa_pkg::req_type                  req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  flfa_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [flfa_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [flfa_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int                                 mismatches,
   output int                                 pending
);
   import flfa_pkg::*;

   // Shadow copy of the settings.
   logic [SIZE_BITS-1:0]  cfg_total;
   logic [SIZE_BITS-1:0]  cfg_base;
   logic [HDR_BITS-1:0]   cfg_header;
   logic [POL_BITS-1:0]   cfg_policy;
   logic [ALIGN_BITS-1:0] cfg_align;

   // Shadow copy of the free list.
   logic [ADDR_BITS-1:0] blk_start [MAX_BLOCKS];
   logic [LEN_BITS-1:0]  blk_len [MAX_BLOCKS];
   int                   blk_count;

   // Responses still owed by the block, oldest first.
   rsp_type     awaited_rsp_q [$];
   int unsigned rsp_seen;

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      mismatches++;
   endtask

   // The list goes back to a single region after reset and after any write to a known index.
   function automatic void rebuild_free_list();
      int i;
      for (i = 0; i < MAX_BLOCKS; i++) begin
         blk_start[i] = '0;
         blk_len[i]   = '0;
      end
      blk_start[0] = ADDR_BITS'(cfg_base);
      blk_len[0]   = LEN_BITS'(cfg_total);
      blk_count    = 1;
   endfunction

   // Allocation: align, add the header, pick a region by policy and carve it.
   function automatic rsp_type grant_from_list(input logic [SIZE_BITS-1:0] req_size);
      int unsigned need;
      int unsigned rem;
      int          i;
      int          pick;
      bit          found;
      bit          done;
      rsp_type     r;
      need = req_size;
      if (cfg_align != '0) begin
         rem = need % cfg_align;
         if (rem != 0) need += cfg_align - rem;
      end
      need += cfg_header;
      found = 1'b0;
      done  = 1'b0;
      pick  = 0;
      for (i = 0; i < blk_count && !done; i++) begin
         if (blk_len[i] >= need) begin
            if (!found) begin
               pick  = i;
               found = 1'b1;
               // Anything but best or worst fit stops at the first hit.
               done  = (cfg_policy != POL_BEST) && (cfg_policy != POL_WORST);
            end else if (cfg_policy == POL_BEST && blk_len[i] < blk_len[pick]) begin
               pick = i;
            end else if (cfg_policy == POL_WORST && blk_len[i] > blk_len[pick]) begin
               pick = i;
            end
         end
      end
      if (!found) begin
         r.granted_address = '0;
         r.status          = STAT_NOFIT;
      end else begin
         r.granted_address = SIZE_BITS'(blk_start[pick]);
         r.status          = STAT_OK;
         blk_start[pick]   = blk_start[pick] + ADDR_BITS'(need);
         blk_len[pick]     = blk_len[pick] - LEN_BITS'(need);
         // An emptied region leaves the list and the rest close up behind it.
         if (blk_len[pick] == '0) begin
            for (i = pick; i + 1 < blk_count; i++) begin
               blk_start[i] = blk_start[i + 1];
               blk_len[i]   = blk_len[i + 1];
            end
            blk_count--;
         end
      end
      return r;
   endfunction

   // Free: the region goes to the head of the list unless the list is full.
   function automatic rsp_type push_freed_region(input logic [SIZE_BITS-1:0] addr,
                                                 input logic [SIZE_BITS-1:0] len);
      int      i;
      rsp_type r;
      r.granted_address = '0;
      if (blk_count >= MAX_BLOCKS) begin
         r.status = STAT_FULL;
      end else begin
         for (i = blk_count; i > 0; i--) begin
            blk_start[i] = blk_start[i - 1];
            blk_len[i]   = blk_len[i - 1];
         end
         blk_start[0] = ADDR_BITS'(addr);
         blk_len[0]   = LEN_BITS'(len);
         blk_count++;
         r.status = STAT_OK;
      end
      return r;
   endfunction

   // Register write as the block sees it; unknown indexes change nothing.
   function automatic void apply_register_write();
      bit known;
      known = 1'b1;
      case (csr_index)
         CSR_TOTAL_SIZE:   cfg_total  = csr_wdata;
         CSR_BASE_ADDRESS: cfg_base   = csr_wdata;
         CSR_HEADER_SIZE:  cfg_header = csr_wdata[HDR_BITS-1:0];
         CSR_FIT_POLICY:   cfg_policy = csr_wdata[POL_BITS-1:0];
         CSR_ALIGNMENT:    cfg_align  = csr_wdata[ALIGN_BITS-1:0];
         default:          known = 1'b0;
      endcase
      if (known) rebuild_free_list();
   endfunction

   // Responses are compared before the prediction of a newly accepted item.
   always @(posedge clock) begin
      rsp_type expected;
      if (reset) begin
         cfg_total  = TOTAL_SIZE_RST;
         cfg_base   = BASE_ADDRESS_RST;
         cfg_header = HEADER_SIZE_RST;
         cfg_policy = FIT_POLICY_RST;
         cfg_align  = ALIGNMENT_RST;
         rebuild_free_list();
         awaited_rsp_q.delete();
         mismatches = 0;
         rsp_seen   = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (awaited_rsp_q.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with none outstanding",
                                         rsp_seen));
            end else begin
               expected = awaited_rsp_q.pop_front();
               if (rsp_data.granted_address !== expected.granted_address)
                  report_mismatch($sformatf("response %0d granted_address %h, predicted %h",
                                            rsp_seen, rsp_data.granted_address,
                                            expected.granted_address));
               if (rsp_data.status !== expected.status)
                  report_mismatch($sformatf("response %0d status %0d, predicted %0d",
                                            rsp_seen, rsp_data.status, expected.status));
            end
         end
         if (csr_we) apply_register_write();
         if (req_valid && req_ready) begin
            if (req_data.command == CMD_FREE)
               awaited_rsp_q.push_back(push_freed_region(req_data.free_address,
                                                         req_data.request_size));
            else
               awaited_rsp_q.push_back(grant_from_list(req_data.request_size));
         end
      end
      pending = awaited_rsp_q.size();
   end

endmodule

/* tb/sv/free_list_fit_allocator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// free_list_fit_allocator_tb: stimulus and verdict for the fit allocator
// Drives allocate and free items through a directed opening and then many
// randomised settings, with random idle bursts on both channels. A checker
// beside the block predicts every response; this module reports the result.
// ----------------------------------------------------------------------------
module free_list_fit_allocator_tb;
   import flfa_pkg::*;

   localparam int unsigned RANDOM_ITEMS  = 1250;
   localparam int unsigned QUIET_ITEMS   = 150;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned LIMIT_CYCLES  = 600000;
   // The fourth policy code has no name in the package; it acts as first fit.
   localparam logic [POL_BITS-1:0] POL_SPARE = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rsp_type                  rsp_data;
   logic                     csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   int          mismatches;
   int          pending;
   bit          gappy = 1'b1;
   bit          tail_quiet = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned cur_total = TOTAL_SIZE_RST;
   int unsigned random_sent = 0;

   free_list_fit_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   flfa_allocation_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("free_list_fit_allocator verification failed");
         $finish;
      end
   end

   // Response side: random stall bursts, calm stretches, none in the tail.
   initial begin
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!tail_quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 200)) @(posedge clock);
         end
      end
   end

   function automatic req_type mk_item(input logic cmd, input int unsigned size,
                                       input int unsigned addr);
      req_type item;
      item.command      = cmd;
      item.request_size = SIZE_BITS'(size);
      item.free_address = SIZE_BITS'(addr);
      return item;
   endfunction

   // Offers one item and returns just after the edge that accepts it.
   task automatic send_item(input req_type item);
      if (gappy && !tail_quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Holds the sender until every outstanding response has been taken.
   task automatic settle_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_BITS'(value);
      @(posedge clock);
   endtask

   // Writes every register back to back; the block must be idle.
   task automatic set_config(input int unsigned total, input int unsigned base,
                             input int unsigned header, input logic [POL_BITS-1:0] policy,
                             input int unsigned align);
      write_reg(CSR_TOTAL_SIZE, total);
      write_reg(CSR_BASE_ADDRESS, base);
      write_reg(CSR_HEADER_SIZE, header);
      write_reg(CSR_FIT_POLICY, policy);
      write_reg(CSR_ALIGNMENT, align);
      csr_we    <= 1'b0;
      cur_total = total;
   endtask

   initial begin
      int unsigned n;
      int unsigned phase_no;
      int unsigned phase_len;
      int unsigned burst_left;
      int unsigned size;
      int unsigned addr;
      int unsigned total;
      int unsigned base;
      int unsigned header;
      int unsigned align;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      reset     <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: zero-size grant, oversize refusal, a zero-length
      // region taken and removed, and a start address that wraps.
      send_item(mk_item(CMD_ALLOC, 0, 0));
      send_item(mk_item(CMD_ALLOC, 16'hFFFF, 16'hFFFF));
      send_item(mk_item(CMD_FREE, 0, 16'hFFFF));
      send_item(mk_item(CMD_ALLOC, 0, 0));
      send_item(mk_item(CMD_FREE, 16'hFFFF, 16'hFFF0));
      send_item(mk_item(CMD_ALLOC, 100, 0));

      // Best fit: a tie goes to the earlier region, and a region longer
      // than the managed size is still chosen when it is the only fit.
      settle_idle();
      set_config(1000, 0, 0, POL_BEST, 0);
      send_item(mk_item(CMD_FREE, 300, 16'h2000));
      send_item(mk_item(CMD_FREE, 300, 16'h3000));
      send_item(mk_item(CMD_ALLOC, 200, 0));
      send_item(mk_item(CMD_FREE, 2000, 16'h8000));
      send_item(mk_item(CMD_ALLOC, 1500, 0));

      // Worst fit with header and alignment: equal largest regions tie.
      settle_idle();
      set_config(1000, 0, 16, POL_WORST, 64);
      send_item(mk_item(CMD_FREE, 1000, 16'h6000));
      send_item(mk_item(CMD_ALLOC, 10, 0));

      // Spare policy code: empty the list, refuse on the empty list, then
      // fill it until a free is dropped.
      settle_idle();
      set_config(100, 16'h0100, 0, POL_SPARE, 0);
      send_item(mk_item(CMD_ALLOC, 100, 0));
      send_item(mk_item(CMD_ALLOC, 0, 0));
      for (n = 0; n < 17; n++) send_item(mk_item(CMD_FREE, n + 1, 16'h1000 + 16 * n));
      send_item(mk_item(CMD_ALLOC, 3, 0));

      // Random phases, each under fresh settings written while idle.
      phase_no   = 0;
      burst_left = 0;
      while (random_sent < RANDOM_ITEMS) begin
         settle_idle();
         if (phase_no == 0) begin
            set_config(65535, 65535, 255, POL_WORST, 4096);
         end else if (phase_no == 1) begin
            set_config(1, 0, 0, POL_BEST, 1);
         end else if (phase_no == 2) begin
            set_config(65535, 0, 0, POL_FIRST, 0);
         end else begin
            case ($urandom_range(0, 5))
               0:       total = 65535;
               1:       total = $urandom_range(1, 16);
               2:       total = $urandom_range(1, 65535);
               default: total = $urandom_range(64, 4096);
            endcase
            case ($urandom_range(0, 3))
               0:       base = 0;
               1:       base = 65535;
               default: base = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 3))
               0:       header = 0;
               1:       header = 255;
               default: header = $urandom_range(0, 32);
            endcase
            case ($urandom_range(0, 5))
               0, 1:    align = 0;
               2:       align = 1 << $urandom_range(0, 12);
               3:       align = 4096;
               default: align = $urandom_range(1, 4096);
            endcase
            set_config(total, base, header, POL_BITS'($urandom_range(0, 3)), align);
         end
         phase_no++;
         gappy     = ($urandom_range(0, 3) != 0);
         phase_len = $urandom_range(60, 140);
         // Once the quiet tail has begun the phase runs on to the last item.
         for (n = 0; (n < phase_len || tail_quiet) && random_sent < RANDOM_ITEMS; n++) begin
            tail_quiet = (random_sent + QUIET_ITEMS >= RANDOM_ITEMS);
            // Now and then the sender waits for every response to return.
            if (!tail_quiet && $urandom_range(0, 249) == 0) settle_idle();
            if (burst_left == 0 && $urandom_range(0, 39) == 0)
               burst_left = $urandom_range(8, 20);
            if (burst_left != 0 || $urandom_range(0, 9) < 3) begin
               if (burst_left != 0) burst_left--;
               case ($urandom_range(0, 9))
                  0:          size = $urandom_range(0, 65535);
                  1:          size = 0;
                  2, 3, 4, 5: size = $urandom_range(1, 8);
                  default:    size = $urandom_range(1, cur_total / 2 + 1);
               endcase
               addr = $urandom_range(0, 65535);
               send_item(mk_item(CMD_FREE, size, addr));
            end else begin
               case ($urandom_range(0, 9))
                  0:       size = $urandom_range(0, 65535);
                  1:       size = 0;
                  2, 3, 4: size = $urandom_range(0, 8);
                  5:       size = $urandom_range(0, 63);
                  default: size = $urandom_range(0, (cur_total / 4 > 0) ? cur_total / 4 : 1);
               endcase
               send_item(mk_item(CMD_ALLOC, size, $urandom_range(0, 65535)));
            end
            random_sent++;
         end
      end

      // Wait for the last responses and let the block go quiet.
      settle_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("free_list_fit_allocator verification clean");
      end else begin
         $display("free_list_fit_allocator verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/flfa_pkg.sv
rtl/flfa_rem.sv
rtl/free_list_fit_allocator.sv
tb/sv/flfa_allocation_checker.sv
tb/sv/free_list_fit_allocator_tb.sv
